// ===== rtl/trace_ring_with_quota_dump_assert.svh =====
// Assertion macros for the trace ring block.
// Used by the top level; expects clk and rst in scope.
`ifndef TRACE_RING_WITH_QUOTA_DUMP_ASSERT_SVH
`define TRACE_RING_WITH_QUOTA_DUMP_ASSERT_SVH

// same-cycle implication
`define TRQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/trq_pkg.sv =====
// Shared types, operation codes and helpers for the trace ring.
// No dependencies.
`timescale 1ns / 1ps
package trq_pkg;

  localparam int CNT_W = 11;

  localparam logic [2:0] OP_RECORD  = 3'd0;
  localparam logic [2:0] OP_CONSUME = 3'd1;
  localparam logic [2:0] OP_RESET   = 3'd2;
  localparam logic [2:0] OP_DUMP    = 3'd3;
  localparam logic [2:0] OP_FETCH   = 3'd4;

  typedef struct packed {
    logic [2:0]  operation;
    logic [15:0] event_type;
    logic [15:0] subsystem;
    logic [30:0] process_id;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [15:0] dump_limit;
    logic [31:0] subsystem_mask;
  } trq_req_t;

  typedef struct packed {
    logic             event_valid;
    logic [63:0]      sequence_res;
    logic [30:0]      event_pid;
    logic [15:0]      kind;
    logic [15:0]      origin_subsystem;
    logic [63:0]      out_word0;
    logic [63:0]      out_word1;
    logic [63:0]      out_word2;
    logic [63:0]      out_word3;
    logic [CNT_W-1:0] stored_or_unread;
    logic [CNT_W-1:0] matched_count;
    logic [CNT_W-1:0] shown_count;
  } trq_res_t;

  typedef struct packed {
    logic [63:0] seq;
    logic [30:0] pid;
    logic [15:0] kind;
    logic [15:0] sub;
    logic [63:0] w0;
    logic [63:0] w1;
    logic [63:0] w2;
    logic [63:0] w3;
  } trq_entry_t;

  function automatic logic mask_hit(input logic [31:0] mask, input logic [15:0] sub);
    return (mask == 32'd0) || ((sub[15:5] == 11'd0) && mask[sub[4:0]]);
  endfunction

endpackage

// ===== rtl/trq_ring.sv =====
// Event ring storage: one write port, one registered read port.
// Depends on trq_pkg.
`timescale 1ns / 1ps
module trq_ring
  import trq_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  trq_entry_t               wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output trq_entry_t               rd_data
);

  trq_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/trq_marks.sv =====
// Dump selection stores: picked map and per-type tally memories.
// Depends on trq_pkg for nothing but house style; registered reads.
`timescale 1ns / 1ps
module trq_marks
  import trq_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int BINS  = 64,
  parameter int CW    = 11
) (
  input  logic                     clk,
  input  logic                     pk_we,
  input  logic [$clog2(DEPTH)-1:0] pk_waddr,
  input  logic                     pk_wdata,
  input  logic [$clog2(DEPTH)-1:0] pk_raddr,
  output logic                     pk_rdata,
  input  logic                     tl_we,
  input  logic [$clog2(BINS)-1:0]  tl_waddr,
  input  logic [CW-1:0]            tl_wdata,
  input  logic [$clog2(BINS)-1:0]  tl_raddr,
  output logic [CW-1:0]            tl_rdata
);

  logic          picked [DEPTH];
  logic [CW-1:0] tally  [BINS];

  always_ff @(posedge clk) begin
    if (pk_we) begin
      picked[pk_waddr] <= pk_wdata;
    end
    pk_rdata <= picked[pk_raddr];
    if (tl_we) begin
      tally[tl_waddr] <= tl_wdata;
    end
    tl_rdata <= tally[tl_raddr];
  end

endmodule

// ===== rtl/trace_ring_with_quota_dump.sv =====
// Trace ring top level: sequencer, counters and result register.
// Record, reset cursor and undefined ops: result in the cycle after the request.
// Consume: S_CONS. Fetch: S_FRD (map read), S_FEV per scanned slot, S_FOUT if picked.
// Dump: S_CLR clears map and tallies, S_P1RD/S_P1EV/S_P1UP per stored event, S_P2RD/S_P2EV
// per backfill event; one ring read port sets the pace. No new request while busy.
// Sync reset clears counters and sequencer; ring contents stay undefined.
`timescale 1ns / 1ps
`include "trace_ring_with_quota_dump_assert.svh"
module trace_ring_with_quota_dump
  import trq_pkg::*;
#(
  parameter int RING_DEPTH = 1024,
  parameter int TYPE_BINS  = 64
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  trq_req_t req,
  output logic     done,
  output trq_res_t res
);

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int BW    = $clog2(TYPE_BINS);
  localparam int CLR_N = (RING_DEPTH > TYPE_BINS) ? RING_DEPTH : TYPE_BINS;
  localparam int KW    = $clog2(CLR_N);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_CONS = 11'b00000000010,
    S_CLR  = 11'b00000000100,
    S_P1RD = 11'b00000001000,
    S_P1EV = 11'b00000010000,
    S_P1UP = 11'b00000100000,
    S_P2RD = 11'b00001000000,
    S_P2EV = 11'b00010000000,
    S_FRD  = 11'b00100000000,
    S_FEV  = 11'b01000000000,
    S_FOUT = 11'b10000000000
  } state_t;

  state_t        state;
  logic [31:0]   wc, rc;
  logic [63:0]   seq;
  logic [AW-1:0] wr_slot, rd_slot, pslot, pstart, base_r, dump_base;
  logic [CW-1:0] fetch_pos, dump_stored, stored_r, lim, quota, idx, matched, sel;
  logic [31:0]   mask;
  logic [KW-1:0] kcnt;
  logic          m_hit;
  logic [BW-1:0] bin;

  trq_entry_t    entry_q, wr_data;
  logic          ring_we;
  logic [AW-1:0] ring_raddr;
  logic          pk_we, pk_wdata, pk_rdata, tl_we;
  logic [AW-1:0] pk_waddr, pk_raddr;
  logic [BW-1:0] tl_waddr, tl_raddr;
  logic [CW-1:0] tl_wdata, tl_rdata;

  logic [AW-1:0] wr_inc, rd_inc, pslot_dec, fslot;
  logic [CW:0]   fsum;
  logic [CW-1:0] idx_m1, idx_inc, sel_after1, sel_after2;
  logic [31:0]   wc_inc, rc_rec;
  logic          ovf, hit_c, take1, take2, full;
  logic [BW-1:0] bin_c;
  logic [CW-1:0] stored_c, lim_c, quota_c;
  logic [CNT_W-1:0] unread_now, unread_rec;

  assign busy = (state != S_IDLE);

  always_comb begin
    wr_inc     = (wr_slot == AW'(RING_DEPTH - 1)) ? '0 : wr_slot + 1'b1;
    rd_inc     = (rd_slot == AW'(RING_DEPTH - 1)) ? '0 : rd_slot + 1'b1;
    pslot_dec  = (pslot == '0) ? AW'(RING_DEPTH - 1) : pslot - 1'b1;
    fsum       = (CW+1)'(dump_base) + (CW+1)'(idx);
    fslot      = (fsum >= (CW+1)'(RING_DEPTH)) ? AW'(fsum - (CW+1)'(RING_DEPTH)) : AW'(fsum);
    idx_m1     = idx - 1'b1;
    idx_inc    = idx + 1'b1;
    wc_inc     = wc + 32'd1;
    ovf        = (wc_inc - rc) > 32'(RING_DEPTH);
    rc_rec     = ovf ? wc_inc - 32'(RING_DEPTH) : rc;
    unread_now = CNT_W'(wc - rc);
    unread_rec = CNT_W'(wc_inc - rc_rec);
    hit_c      = mask_hit(mask, entry_q.sub);
    bin_c      = (entry_q.kind >= 16'(TYPE_BINS)) ? BW'(TYPE_BINS - 1) : BW'(entry_q.kind);
    take1      = m_hit && (sel < lim) && (tl_rdata < quota);
    take2      = hit_c && !pk_rdata;
    sel_after1 = sel + CW'(take1);
    sel_after2 = sel + CW'(take2);
    full       = wc >= 32'(RING_DEPTH);
    stored_c   = full ? CW'(RING_DEPTH) : CW'(wc);
    lim_c      = ((req.dump_limit == 16'd0) || (32'(req.dump_limit) > 32'(RING_DEPTH)))
                 ? CW'(RING_DEPTH) : CW'(req.dump_limit);
    quota_c    = ((lim_c >> 2) < CW'(2)) ? CW'(2) : (lim_c >> 2);
  end

  always_comb begin
    wr_data.seq  = seq + 64'd1;
    wr_data.pid  = req.process_id;
    wr_data.kind = req.event_type;
    wr_data.sub  = req.subsystem;
    wr_data.w0   = req.word0;
    wr_data.w1   = req.word1;
    wr_data.w2   = req.word2;
    wr_data.w3   = req.word3;
    ring_we      = (state == S_IDLE) && start && (req.operation == OP_RECORD);
  end

  always_comb begin
    ring_raddr = rd_slot;
    pk_we      = 1'b0;
    pk_waddr   = idx_m1[AW-1:0];
    pk_wdata   = 1'b1;
    pk_raddr   = idx_m1[AW-1:0];
    tl_we      = 1'b0;
    tl_waddr   = bin;
    tl_wdata   = tl_rdata + 1'b1;
    tl_raddr   = bin_c;
    unique case (state)
      S_CLR: begin
        pk_we    = (32'(kcnt) < 32'(RING_DEPTH));
        pk_waddr = AW'(kcnt);
        pk_wdata = 1'b0;
        tl_we    = (32'(kcnt) < 32'(TYPE_BINS));
        tl_waddr = BW'(kcnt);
        tl_wdata = '0;
      end
      S_P1RD, S_P2RD: ring_raddr = pslot;
      S_P1UP: begin
        pk_we = take1;
        tl_we = take1;
      end
      S_P2EV: pk_we = take2;
      S_FRD: pk_raddr = idx[AW-1:0];
      S_FEV: ring_raddr = fslot;
      default: ;
    endcase
  end

  trq_ring #(.DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .wr_en   (ring_we),
    .wr_addr (wr_slot),
    .wr_data (wr_data),
    .rd_addr (ring_raddr),
    .rd_data (entry_q)
  );

  trq_marks #(.DEPTH(RING_DEPTH), .BINS(TYPE_BINS), .CW(CW)) u_marks (
    .clk      (clk),
    .pk_we    (pk_we),
    .pk_waddr (pk_waddr),
    .pk_wdata (pk_wdata),
    .pk_raddr (pk_raddr),
    .pk_rdata (pk_rdata),
    .tl_we    (tl_we),
    .tl_waddr (tl_waddr),
    .tl_wdata (tl_wdata),
    .tl_raddr (tl_raddr),
    .tl_rdata (tl_rdata)
  );

  function automatic trq_res_t cnt_res(input logic [CNT_W-1:0] n);
    trq_res_t r;
    r = '0;
    r.stored_or_unread = n;
    return r;
  endfunction

  function automatic trq_res_t ev_res(input trq_entry_t e, input logic [CNT_W-1:0] n);
    trq_res_t r;
    r                  = '0;
    r.event_valid      = 1'b1;
    r.sequence_res     = e.seq;
    r.event_pid        = e.pid;
    r.kind             = e.kind;
    r.origin_subsystem = e.sub;
    r.out_word0        = e.w0;
    r.out_word1        = e.w1;
    r.out_word2        = e.w2;
    r.out_word3        = e.w3;
    r.stored_or_unread = n;
    return r;
  endfunction

  function automatic trq_res_t dump_res(input logic [CW-1:0] s, input logic [CW-1:0] m,
                                        input logic [CW-1:0] k);
    trq_res_t r;
    r                  = '0;
    r.stored_or_unread = CNT_W'(s);
    r.matched_count    = CNT_W'(m);
    r.shown_count      = CNT_W'(k);
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wc          <= '0;
      rc          <= '0;
      seq         <= '0;
      wr_slot     <= '0;
      rd_slot     <= '0;
      fetch_pos   <= '0;
      dump_base   <= '0;
      dump_stored <= '0;
      sel         <= '0;
      lim         <= '0;
      done        <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            unique case (req.operation)
              OP_RECORD: begin
                seq     <= seq + 64'd1;
                wc      <= wc_inc;
                wr_slot <= wr_inc;
                rc      <= rc_rec;
                if (ovf) begin
                  rd_slot <= wr_inc;
                end
                res  <= cnt_res(unread_rec);
                done <= 1'b1;
              end
              OP_CONSUME: begin
                if (wc != rc) begin
                  rc      <= rc + 32'd1;
                  rd_slot <= rd_inc;
                  state   <= S_CONS;
                end else begin
                  res  <= cnt_res(unread_now);
                  done <= 1'b1;
                end
              end
              OP_RESET: begin
                rc      <= wc;
                rd_slot <= wr_slot;
                res     <= cnt_res('0);
                done    <= 1'b1;
              end
              OP_DUMP: begin
                stored_r <= stored_c;
                base_r   <= full ? wr_slot : '0;
                pstart   <= (wr_slot == '0) ? AW'(RING_DEPTH - 1) : wr_slot - 1'b1;
                lim      <= lim_c;
                quota    <= quota_c;
                mask     <= req.subsystem_mask;
                matched  <= '0;
                sel      <= '0;
                kcnt     <= '0;
                state    <= S_CLR;
              end
              OP_FETCH: begin
                idx <= fetch_pos;
                if (fetch_pos < dump_stored) begin
                  state <= S_FRD;
                end else begin
                  fetch_pos <= dump_stored;
                  res       <= cnt_res(unread_now);
                  done      <= 1'b1;
                end
              end
              default: begin
                res  <= cnt_res(unread_now);
                done <= 1'b1;
              end
            endcase
          end
        end
        S_CONS: begin
          res   <= ev_res(entry_q, unread_now);
          done  <= 1'b1;
          state <= S_IDLE;
        end
        S_CLR: begin
          kcnt <= kcnt + 1'b1;
          if (32'(kcnt) == 32'(CLR_N - 1)) begin
            idx   <= stored_r;
            pslot <= pstart;
            if (stored_r == '0) begin
              res         <= dump_res(stored_r, '0, '0);
              dump_base   <= base_r;
              dump_stored <= stored_r;
              fetch_pos   <= '0;
              done        <= 1'b1;
              state       <= S_IDLE;
            end else begin
              state <= S_P1RD;
            end
          end
        end
        S_P1RD: state <= S_P1EV;
        S_P1EV: begin
          m_hit <= hit_c;
          bin   <= bin_c;
          if (hit_c) begin
            matched <= matched + 1'b1;
          end
          state <= S_P1UP;
        end
        S_P1UP: begin
          sel <= sel_after1;
          if (idx == CW'(1)) begin
            idx   <= stored_r;
            pslot <= pstart;
            if (sel_after1 >= lim) begin
              res         <= dump_res(stored_r, matched, sel_after1);
              dump_base   <= base_r;
              dump_stored <= stored_r;
              fetch_pos   <= '0;
              done        <= 1'b1;
              state       <= S_IDLE;
            end else begin
              state <= S_P2RD;
            end
          end else begin
            idx   <= idx_m1;
            pslot <= pslot_dec;
            state <= S_P1RD;
          end
        end
        S_P2RD: state <= S_P2EV;
        S_P2EV: begin
          sel   <= sel_after2;
          idx   <= idx_m1;
          pslot <= pslot_dec;
          if ((idx == CW'(1)) || (sel_after2 >= lim)) begin
            res         <= dump_res(stored_r, matched, sel_after2);
            dump_base   <= base_r;
            dump_stored <= stored_r;
            fetch_pos   <= '0;
            done        <= 1'b1;
            state       <= S_IDLE;
          end else begin
            state <= S_P2RD;
          end
        end
        S_FRD: state <= S_FEV;
        S_FEV: begin
          if (pk_rdata) begin
            state <= S_FOUT;
          end else if (idx_inc >= dump_stored) begin
            fetch_pos <= dump_stored;
            res       <= cnt_res(unread_now);
            done      <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx   <= idx_inc;
            state <= S_FRD;
          end
        end
        S_FOUT: begin
          res       <= ev_res(entry_q, unread_now);
          fetch_pos <= idx_inc;
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TRQ_ASSERT_NEXT(a_req_progress, start && !busy, done || busy, "request made no progress")
  `TRQ_ASSERT_IMPL(a_sel_bound, state != S_IDLE && state != S_CLR, sel <= lim, "selection over limit")
  `TRQ_ASSERT_IMPL(a_empty_zero, done && !res.event_valid, res.sequence_res == 64'd0 && res.kind == 16'd0, "stale event fields")
  `TRQ_ASSERT_IMPL(a_unread_bound, 1'b1, (wc - rc) <= 32'(RING_DEPTH), "unread count over depth")

endmodule
